// ----- sv/att_fbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_fbt_pkg
// Types and constants shared by the Find By Type Value response checker.
// ----------------------------------------------------------------------------
package att_fbt_pkg;

  localparam int unsigned HANDLE_W = 16;
  localparam logic [HANDLE_W-1:0] HANDLE_TOP  = 16'hFFFF;
  localparam logic [HANDLE_W-1:0] HANDLE_NONE = 16'h0000;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_FOUND_LO = 2'd0,
    PH_FOUND_HI = 2'd1,
    PH_END_LO   = 2'd2,
    PH_END_HI   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] range_first;
    logic [HANDLE_W-1:0] range_last;
    logic                more_wanted;
    logic [7:0]          data_byte;
  } att_fbt_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] search_first;
    logic [HANDLE_W-1:0] search_last;
    logic                continuing;
    logic [HANDLE_W-1:0] expected_next;
    phase_t              byte_phase;
    logic [HANDLE_W-1:0] pair_found;
    logic [7:0]          low_byte_hold;
    logic                error_seen;
  } att_fbt_state_t;

  typedef struct packed {
    logic                status;
    logic                still_continuing;
    logic [HANDLE_W-1:0] next_start;
  } att_fbt_result_t;

endpackage

// ----- sv/att_fbt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_fbt_step
// Next-state and result logic for one item of the response checker.
// ----------------------------------------------------------------------------
module att_fbt_step
  import att_fbt_pkg::*;
(
  input  att_fbt_item_t   item,
  input  att_fbt_state_t  st,
  output att_fbt_state_t  st_nxt,
  output logic            has_result,
  output att_fbt_result_t result
);

  logic [HANDLE_W-1:0] group_end;
  logic                pair_bad;
  logic                end_err;

  assign group_end = {item.data_byte, st.low_byte_hold};
  // expected_next of zero means no further pair may follow
  assign pair_bad  = (st.pair_found > group_end) || (st.pair_found < st.expected_next) ||
                     (st.pair_found > st.search_last) || (st.expected_next == HANDLE_NONE);
  assign end_err   = st.error_seen || (st.byte_phase != PH_FOUND_LO);

  always_comb begin
    st_nxt     = st;
    has_result = 1'b0;
    case (item.kind)
      KIND_BEGIN: begin
        st_nxt.search_first  = item.range_first;
        st_nxt.search_last   = item.range_last;
        st_nxt.continuing    = item.more_wanted;
        st_nxt.expected_next = item.range_first;
        st_nxt.byte_phase    = PH_FOUND_LO;
        st_nxt.pair_found    = '0;
        st_nxt.low_byte_hold = '0;
        st_nxt.error_seen    = 1'b0;
      end
      KIND_BYTE: begin
        if (!st.error_seen) begin
          case (st.byte_phase)
            PH_FOUND_LO: begin
              st_nxt.low_byte_hold = item.data_byte;
              st_nxt.byte_phase    = PH_FOUND_HI;
            end
            PH_FOUND_HI: begin
              st_nxt.pair_found = {item.data_byte, st.low_byte_hold};
              st_nxt.byte_phase = PH_END_LO;
            end
            PH_END_LO: begin
              st_nxt.low_byte_hold = item.data_byte;
              st_nxt.byte_phase    = PH_END_HI;
            end
            default: begin
              st_nxt.byte_phase = PH_FOUND_LO;
              if (pair_bad) begin
                st_nxt.error_seen = 1'b1;
              end else if (group_end == HANDLE_TOP) begin
                st_nxt.expected_next = HANDLE_NONE;
              end else begin
                st_nxt.expected_next = group_end + 16'd1;
              end
            end
          endcase
        end
      end
      KIND_END: begin
        has_result        = 1'b1;
        st_nxt.error_seen = end_err;
        if (!end_err && st.continuing) begin
          if ((st.expected_next == HANDLE_NONE) || (st.expected_next > st.search_last)) begin
            st_nxt.continuing = 1'b0;
          end else begin
            st_nxt.search_first = st.expected_next;
          end
        end
      end
      default: begin
        // unused kind code: item dropped
      end
    endcase
    result.status           = st_nxt.error_seen;
    result.still_continuing = st_nxt.continuing;
    result.next_start       = st_nxt.search_first;
  end

endmodule

// ----- sv/att_find_by_type_response_checker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_find_by_type_response_checker_core
// Checks the handle list of an ATT Find By Type Value response.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the input stalls. Each transfer lands in an input
// register; from there the check logic updates the handle state and, for
// an end item, loads the result register once the output side is free.
// Begin and byte items give no result. The input only stalls when an end
// item is waiting behind a result that the output side has not yet taken;
// the single result register sets that limit.
module att_find_by_type_response_checker_core
  import att_fbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [HANDLE_W-1:0] in_range_first,
  input  logic [HANDLE_W-1:0] in_range_last,
  input  logic                in_more_wanted,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_status,
  output logic                out_still_continuing,
  output logic [HANDLE_W-1:0] out_next_start
);

  logic            item_valid_r;
  att_fbt_item_t   item_r;
  att_fbt_state_t  st_r;
  att_fbt_state_t  st_nxt;
  logic            has_result;
  att_fbt_result_t result;
  logic            res_valid_r;
  att_fbt_result_t res_r;
  logic            out_free;
  logic            advance;
  logic            in_take;

  att_fbt_step u_step (
    .item       (item_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .has_result (has_result),
    .result     (result)
  );

  assign out_free = !res_valid_r || !out_stall;
  // non-end items never wait on the output side
  assign advance  = item_valid_r && (!has_result || out_free);
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take || advance) begin
      item_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind        <= in_kind;
      item_r.range_first <= in_range_first;
      item_r.range_last  <= in_range_last;
      item_r.more_wanted <= in_more_wanted;
      item_r.data_byte   <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && has_result) begin
      res_r <= result;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_status           = res_r.status;
  assign out_still_continuing = res_r.still_continuing;
  assign out_next_start       = res_r.next_start;

`ifndef SYNTHESIS
  a_begin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.kind == KIND_BEGIN) |=>
      (st_r.expected_next == st_r.search_first && !st_r.error_seen))
    else $error("begin did not load expected handle");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.error_seen && !(advance && item_r.kind == KIND_BEGIN)) |=> st_r.error_seen)
    else $error("error cleared without begin");

  a_cont_set_by_begin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.continuing) |-> $past(advance && item_r.kind == KIND_BEGIN))
    else $error("continuing flag set outside begin");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.kind == KIND_END) |=> res_valid_r)
    else $error("end item produced no result");
`endif

endmodule

// ----- tb/sv/att_fbt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_fbt_checker
// Watches both channels of the Find By Type Value response checker, tracks
// the handle list state on every input transfer and compares each result.
// ----------------------------------------------------------------------------
module att_fbt_checker
  import att_fbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [HANDLE_W-1:0] in_range_first,
  input  logic [HANDLE_W-1:0] in_range_last,
  input  logic                in_more_wanted,
  input  logic [7:0]          in_data_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_status,
  input  logic                out_still_continuing,
  input  logic [HANDLE_W-1:0] out_next_start,
  output int                  fail_count,
  output int                  pending,
  output int                  verdict_count,
  output int                  invalid_count,
  output int                  continuing_count
);

  logic [HANDLE_W-1:0] rng_first;
  logic [HANDLE_W-1:0] rng_last;
  logic                cont;
  logic [HANDLE_W-1:0] next_ok;
  phase_t              phase;
  logic [HANDLE_W-1:0] found_h;
  logic [7:0]          lo_hold;
  logic                err;

  att_fbt_result_t verdict_q[$];
  att_fbt_result_t want;

  task automatic track_byte(input logic [7:0] b);
    logic [HANDLE_W-1:0] grp_end;
    if (err) return;
    case (phase)
      PH_FOUND_LO: begin
        lo_hold = b;
        phase   = PH_FOUND_HI;
      end
      PH_FOUND_HI: begin
        found_h = {b, lo_hold};
        phase   = PH_END_LO;
      end
      PH_END_LO: begin
        lo_hold = b;
        phase   = PH_END_HI;
      end
      default: begin
        grp_end = {b, lo_hold};
        phase   = PH_FOUND_LO;
        // next_ok of zero: nothing more allowed (range start 0 or list hit the top)
        if (found_h > grp_end || found_h < next_ok || found_h > rng_last ||
            next_ok == HANDLE_NONE) begin
          err = 1'b1;
        end else begin
          next_ok = (grp_end == HANDLE_TOP) ? HANDLE_NONE : grp_end + 16'd1;
        end
      end
    endcase
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [HANDLE_W-1:0] first,
                              input logic [HANDLE_W-1:0] last, input logic more,
                              input logic [7:0] b);
    case (kind)
      KIND_BEGIN: begin
        rng_first = first;
        rng_last  = last;
        cont      = more;
        next_ok   = first;
        phase     = PH_FOUND_LO;
        found_h   = '0;
        lo_hold   = '0;
        err       = 1'b0;
      end
      KIND_BYTE: track_byte(b);
      KIND_END: begin
        if (!err && phase != PH_FOUND_LO) err = 1'b1;
        if (!err && cont) begin
          if (next_ok == HANDLE_NONE || next_ok > rng_last) cont = 1'b0;
          else rng_first = next_ok;
        end
        verdict_q.push_back('{status: err, still_continuing: cont, next_start: rng_first});
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rng_first = '0;
      rng_last  = '0;
      cont      = 1'b0;
      next_ok   = '0;
      phase     = PH_FOUND_LO;
      found_h   = '0;
      lo_hold   = '0;
      err       = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        verdict_count++;
        if (out_status) invalid_count++;
        if (out_still_continuing) continuing_count++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, %s %0d cont %0d start 0x%0h",
                   $time, "got status", out_status, out_still_continuing, out_next_start);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("still_continuing", 32'(want.still_continuing),
                      32'(out_still_continuing));
          check_field("next_start", 32'(want.next_start), 32'(out_next_start));
        end
      end
      if (in_valid && !in_stall)
        predict_item(in_kind, in_range_first, in_range_last, in_more_wanted, in_data_byte);
    end
    pending <= verdict_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Find By Type Value response checker.
// ----------------------------------------------------------------------------
// Sends a few directed lookups, then mostly well-formed random lookups with
// occasional flawed pairs, partial pairs and noise. The sender runs in bursts,
// the receiver stalls in changing patterns and once holds off long enough to
// back the block up. A separate checker predicts and compares every result.
module tb;
  import att_fbt_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_kind = KIND_BEGIN;
  logic [HANDLE_W-1:0] in_range_first = '0;
  logic [HANDLE_W-1:0] in_range_last = '0;
  logic                in_more_wanted = 1'b0;
  logic [7:0]          in_data_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_status;
  logic                out_still_continuing;
  logic [HANDLE_W-1:0] out_next_start;
  logic                hold_go = 1'b0;

  int fail_count, pending, verdict_count, invalid_count, continuing_count;
  int items_sent = 0;
  int burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  att_find_by_type_response_checker_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_range_first       (in_range_first),
    .in_range_last        (in_range_last),
    .in_more_wanted       (in_more_wanted),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_still_continuing (out_still_continuing),
    .out_next_start       (out_next_start)
  );

  att_fbt_checker i_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_range_first       (in_range_first),
    .in_range_last        (in_range_last),
    .in_more_wanted       (in_more_wanted),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_still_continuing (out_still_continuing),
    .out_next_start       (out_next_start),
    .fail_count           (fail_count),
    .pending              (pending),
    .verdict_count        (verdict_count),
    .invalid_count        (invalid_count),
    .continuing_count     (continuing_count)
  );

  function automatic logic [HANDLE_W-1:0] sat16(input int v);
    return (v > 65535) ? HANDLE_TOP : v[HANDLE_W-1:0];
  endfunction

  // One transfer on the input side; bursts end with a random gap.
  task automatic push_item(input kind_t k, input logic [HANDLE_W-1:0] f,
                           input logic [HANDLE_W-1:0] l, input logic m,
                           input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_range_first <= f;
    in_range_last  <= l;
    in_more_wanted <= m;
    in_data_byte   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_begin(input logic [HANDLE_W-1:0] f, input logic [HANDLE_W-1:0] l,
                            input logic m);
    push_item(KIND_BEGIN, f, l, m, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(KIND_BYTE, 16'($urandom), 16'($urandom), 1'($urandom), b);
  endtask

  task automatic send_end();
    push_item(KIND_END, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_pair(input logic [HANDLE_W-1:0] fd, input logic [HANDLE_W-1:0] ge);
    send_byte(fd[7:0]);
    send_byte(fd[15:8]);
    send_byte(ge[7:0]);
    send_byte(ge[15:8]);
  endtask

  // Random lookup: mostly a proper begin / pairs / end, sometimes flawed, else noise.
  task automatic run_lookup();
    logic [HANDLE_W-1:0] f, l, nx, fd, ge;
    int npairs, flaw, i;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 9))
        0:       f = HANDLE_NONE;
        1:       f = HANDLE_TOP - 16'($urandom_range(0, 8));
        2:       f = 16'($urandom);
        default: f = 16'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 9))
        0:       l = 16'($urandom);
        1:       l = HANDLE_TOP;
        2:       l = f - 16'($urandom_range(1, 4));
        default: l = sat16(int'(f) + $urandom_range(0, 60));
      endcase
      send_begin(f, l, 1'($urandom_range(0, 1)));
      nx     = f;
      npairs = $urandom_range(0, 4);
      flaw   = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 5) : 0;
      for (i = 0; i < npairs; i++) begin
        fd = sat16(int'(nx) + $urandom_range(0, 3));
        ge = sat16(int'(fd) + $urandom_range(0, 6));
        if ($urandom_range(0, 19) == 0) ge = HANDLE_TOP;
        if (i == npairs - 1) begin
          case (flaw)
            1: begin
              if (fd == HANDLE_NONE) fd = 16'd1;
              ge = fd - 16'($urandom_range(1, int'(fd) < 3 ? int'(fd) : 3));
            end
            2: fd = nx - 16'($urandom_range(1, 3));
            3: begin
              fd = sat16(int'(l) + $urandom_range(1, 5));
              ge = HANDLE_TOP;
            end
            4: ge = HANDLE_TOP;
            default: ;
          endcase
        end
        send_pair(fd, ge);
        nx = (ge == HANDLE_TOP) ? HANDLE_NONE : ge + 16'd1;
      end
      // a pair following one that closed at the top handle
      if (flaw == 4 && npairs > 0) send_pair(16'($urandom), 16'($urandom));
      if (flaw == 5) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      send_end();
      if ($urandom_range(0, 7) == 0) send_end();
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0:       send_begin(16'($urandom), 16'($urandom), 1'($urandom));
          4:       send_end();
          default: send_byte(8'($urandom));
        endcase
      end
    end
  endtask

  // Receiver stall pattern, with one long hold-off on request.
  initial begin : rx_pattern
    int mode, span, k;
    bit held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_go && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit hold_done;
    hold_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any begin: complete pair checked against reset state
    send_pair(16'h0001, 16'h0002);
    send_end();
    // full range, list closes at the top handle, continuation clears
    send_begin(16'h0001, HANDLE_TOP, 1'b1);
    send_pair(16'h0001, HANDLE_TOP);
    send_end();
    // continuing lookup, then a repeated end item
    send_begin(16'h0010, 16'h0020, 1'b1);
    send_pair(16'h0010, 16'h0014);
    send_end();
    send_end();
    // partial pair at the end
    send_begin(16'h0005, 16'hFF00, 1'b0);
    send_byte(8'hFF);
    send_end();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent > 400) begin
        hold_go   <= 1'b1;
        hold_done = 1'b1;
      end
      run_lookup();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d items; checked %0d verdicts (%0d invalid, %0d continuing).",
             items_sent, verdict_count, invalid_count, continuing_count);
    $display("Run included flawed and partial pairs, noise and a long output hold-off.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
